/* rtl/core/qsu_pkg.sv */
// qsu_pkg: types, character codes and result helpers for the quoted string unescaper.
// No dependencies; used by qsu_decode, qsu_out_fifo and quoted_string_unescaper_top.
`timescale 1ns / 1ps

package qsu_pkg;

	localparam logic [7:0] QUOTE_CHAR     = 8'h22;
	localparam logic [7:0] BACKSLASH_CHAR = 8'h5C;
	localparam logic [7:0] LETTER_N       = 8'h6E;
	localparam logic [7:0] LETTER_T       = 8'h74;
	localparam logic [7:0] NEWLINE_CHAR   = 8'h0A;
	localparam logic [7:0] TAB_CHAR       = 8'h09;

	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_END  = 1'b1;

	localparam logic [1:0] QST_NONE   = 2'd0;
	localparam logic [1:0] QST_CLOSED = 2'd1;
	localparam logic [1:0] QST_OPEN   = 2'd2;

	localparam int OUT_DEPTH_DEFAULT = 4;

	typedef enum logic [2:0] {
		MODE_BEFORE = 3'd0,
		MODE_INSIDE = 3'd1,
		MODE_BSLASH = 3'd2,
		MODE_QPEND  = 3'd3,
		MODE_AFTER  = 3'd4
	} mode_t;

	typedef struct packed {
		logic       action;
		logic [7:0] byte_value;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_status;
		logic [1:0] quote_status;
		logic       last;
	} out_item_t;

	// decode of one item: up to two results and the mode that follows
	typedef struct packed {
		logic [1:0] count;
		out_item_t  res0;
		out_item_t  res1;
		mode_t      next_mode;
	} dec_t;

	function automatic out_item_t byte_res(input logic [7:0] b);
		out_item_t r;
		r.out_byte     = b;
		r.is_status    = 1'b0;
		r.quote_status = QST_NONE;
		r.last         = 1'b0;
		return r;
	endfunction

	function automatic out_item_t status_res(input logic [1:0] st);
		out_item_t r;
		r.out_byte     = 8'h00;
		r.is_status    = 1'b1;
		r.quote_status = st;
		r.last         = 1'b0;
		return r;
	endfunction

endpackage

/* rtl/core/qsu_stream_if.sv */
// qsu_stream_if: valid/ready channel carrying one item of type payload_t.
// No dependencies.
`timescale 1ns / 1ps

interface qsu_stream_if #(
	parameter type payload_t = logic [7:0]
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/qsu_decode.sv */
// qsu_decode: per-item decode from current scan mode to results and next mode.
// Depends on qsu_pkg.
`timescale 1ns / 1ps

module qsu_decode (
	input  qsu_pkg::mode_t    mode,
	input  qsu_pkg::in_item_t item,
	output qsu_pkg::dec_t     dec
);

	logic [7:0] b;

	assign b = item.byte_value;

	always_comb begin
		dec.count     = 2'd0;
		dec.res0      = qsu_pkg::byte_res(b);
		dec.res1      = qsu_pkg::byte_res(b);
		dec.next_mode = mode;
		if (item.action == qsu_pkg::ACT_END) begin
			dec.next_mode = qsu_pkg::MODE_BEFORE;
			dec.count     = 2'd1;
			case (mode)
				qsu_pkg::MODE_INSIDE: begin
					dec.res0 = qsu_pkg::status_res(qsu_pkg::QST_OPEN);
				end
				qsu_pkg::MODE_BSLASH: begin
					// flush the pending backslash ahead of the status
					dec.count = 2'd2;
					dec.res0  = qsu_pkg::byte_res(qsu_pkg::BACKSLASH_CHAR);
					dec.res1  = qsu_pkg::status_res(qsu_pkg::QST_OPEN);
				end
				qsu_pkg::MODE_QPEND, qsu_pkg::MODE_AFTER: begin
					dec.res0 = qsu_pkg::status_res(qsu_pkg::QST_CLOSED);
				end
				default: begin
					dec.res0 = qsu_pkg::status_res(qsu_pkg::QST_NONE);
				end
			endcase
		end else begin
			case (mode)
				qsu_pkg::MODE_INSIDE: begin
					if (b == qsu_pkg::QUOTE_CHAR) begin
						dec.next_mode = qsu_pkg::MODE_QPEND;
					end else if (b == qsu_pkg::BACKSLASH_CHAR) begin
						dec.next_mode = qsu_pkg::MODE_BSLASH;
					end else begin
						dec.count = 2'd1;
					end
				end
				qsu_pkg::MODE_BSLASH: begin
					dec.count = 2'd1;
					if (b == qsu_pkg::LETTER_N) begin
						dec.res0      = qsu_pkg::byte_res(qsu_pkg::NEWLINE_CHAR);
						dec.next_mode = qsu_pkg::MODE_INSIDE;
					end else if (b == qsu_pkg::LETTER_T) begin
						dec.res0      = qsu_pkg::byte_res(qsu_pkg::TAB_CHAR);
						dec.next_mode = qsu_pkg::MODE_INSIDE;
					end else begin
						// backslash goes out as is, then b is handled as a plain inside byte
						dec.res0 = qsu_pkg::byte_res(qsu_pkg::BACKSLASH_CHAR);
						if (b == qsu_pkg::QUOTE_CHAR) begin
							dec.next_mode = qsu_pkg::MODE_QPEND;
						end else if (b == qsu_pkg::BACKSLASH_CHAR) begin
							dec.next_mode = qsu_pkg::MODE_BSLASH;
						end else begin
							dec.count     = 2'd2;
							dec.next_mode = qsu_pkg::MODE_INSIDE;
						end
					end
				end
				qsu_pkg::MODE_QPEND: begin
					dec.count = 2'd1;
					if (b == qsu_pkg::QUOTE_CHAR) begin
						dec.next_mode = qsu_pkg::MODE_INSIDE;
					end else begin
						dec.next_mode = qsu_pkg::MODE_AFTER;
					end
				end
				qsu_pkg::MODE_AFTER: begin
					if (b != qsu_pkg::QUOTE_CHAR) begin
						dec.count = 2'd1;
					end
				end
				default: begin
					if (b == qsu_pkg::QUOTE_CHAR) begin
						dec.next_mode = qsu_pkg::MODE_INSIDE;
					end else begin
						dec.next_mode = qsu_pkg::MODE_BEFORE;
						dec.count     = 2'd1;
					end
				end
			endcase
		end
		if (dec.count == 2'd1) begin
			dec.res0.last = 1'b1;
		end
		if (dec.count == 2'd2) begin
			dec.res1.last = 1'b1;
		end
	end

endmodule

/* rtl/core/qsu_out_fifo.sv */
// qsu_out_fifo: small register FIFO for results, up to two writes and one read per cycle.
// Depends on qsu_pkg.
`timescale 1ns / 1ps

module qsu_out_fifo #(
	parameter int DEPTH = qsu_pkg::OUT_DEPTH_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          wr_n,
	input  qsu_pkg::out_item_t  wr_d0,
	input  qsu_pkg::out_item_t  wr_d1,
	output logic                room2,
	qsu_stream_if.source        result
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	qsu_pkg::out_item_t mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q, wr_ptr_p1;
	logic [CNT_W-1:0]   count_q;
	logic               pop;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == LAST_PTR) ? '0 : p + PTR_W'(1);
	endfunction

	assign wr_ptr_p1      = ptr_inc(wr_ptr_q);
	assign pop            = result.valid && result.ready;
	assign result.valid   = (count_q != '0);
	assign result.payload = mem_q[rd_ptr_q];
	assign room2          = (count_q <= CNT_W'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (wr_n != 2'd0) begin
			mem_q[wr_ptr_q] <= wr_d0;
		end
		if (wr_n == 2'd2) begin
			mem_q[wr_ptr_p1] <= wr_d1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			case (wr_n)
				2'd1:    wr_ptr_q <= wr_ptr_p1;
				2'd2:    wr_ptr_q <= ptr_inc(wr_ptr_p1);
				default: wr_ptr_q <= wr_ptr_q;
			endcase
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			count_q <= count_q + CNT_W'(wr_n) - CNT_W'(pop);
		end
	end

endmodule

/* rtl/core/quoted_string_unescaper_top.sv */
// quoted_string_unescaper_top: quoted string decoder, one byte in, up to two results out.
// Depends on qsu_pkg, qsu_stream_if, qsu_decode, qsu_out_fifo.
//
// Takes one string byte or end marker per cycle on text, unless the input stalls, and returns
// decoded bytes and an end-of-string status on result. An input item is registered, decoded
// against the scan mode and written as zero, one or two results into an OUT_DEPTH-entry output
// FIFO, so a result passes through the input register and a FIFO entry. Input throughput is
// one item per cycle unless stalled; the output port drains one result per cycle while ready
// is high, so an item that yields two results (a backslash followed by an ordinary byte, or a
// backslash pending at the end) costs one extra output transfer. An item waits in the input
// register, and the input stalls behind it, while the FIFO has fewer than two free entries.
`timescale 1ns / 1ps

module quoted_string_unescaper_top #(
	parameter int OUT_DEPTH = qsu_pkg::OUT_DEPTH_DEFAULT
) (
	input  logic         clk,
	input  logic         arst_n,
	qsu_stream_if.sink   text,
	qsu_stream_if.source result
);

	qsu_pkg::in_item_t item_s1;
	logic              valid_s1;
	qsu_pkg::mode_t    mode_q;
	qsu_pkg::dec_t     dec;
	logic              room2;
	logic              fire_s1;
	logic [1:0]        wr_n;

	assign fire_s1    = valid_s1 && room2;
	assign text.ready = !valid_s1 || fire_s1;
	assign wr_n       = fire_s1 ? dec.count : 2'd0;

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			item_s1 <= text.payload;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q   <= qsu_pkg::MODE_BEFORE;
		end else begin
			if (text.ready) begin
				valid_s1 <= text.valid;
			end
			if (fire_s1) begin
				mode_q <= dec.next_mode;
			end
		end
	end

	qsu_decode u_decode (
		.mode (mode_q),
		.item (item_s1),
		.dec  (dec)
	);

	qsu_out_fifo #(
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_n   (wr_n),
		.wr_d0  (dec.res0),
		.wr_d1  (dec.res1),
		.room2  (room2),
		.result (result)
	);

	// two results only come from a pending backslash
	a_two_from_bslash: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && dec.count == 2'd2) |-> (mode_q == qsu_pkg::MODE_BSLASH))
		else $error("two results without pending backslash");

	a_end_resets_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && item_s1.action == qsu_pkg::ACT_END) |=> (mode_q == qsu_pkg::MODE_BEFORE))
		else $error("end item did not return scan mode to before");

	a_stalled_item_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !room2) |=> (valid_s1 && $stable(item_s1) && $stable(mode_q)))
		else $error("stalled item lost or changed");

	a_status_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.payload.is_status) |-> result.payload.last)
		else $error("status result not marked last");

endmodule

/* tb/quoted_string_unescaper_top_test.sv */
// quoted_string_unescaper_top_test: self-checking bench for quoted_string_unescaper_top.
// Drives a directed table, then random strings, and scores every result in order.
// Depends on qsu_pkg, qsu_stream_if and the RTL under rtl/core.
`timescale 1ns / 1ps

module quoted_string_unescaper_top_test;

	localparam int RANDOM_ITEMS   = 1250;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES   = 8;

	typedef struct {
		qsu_pkg::in_item_t  item;
		bit                 typed;
		int                 n;
		qsu_pkg::out_item_t r0;
		qsu_pkg::out_item_t r1;
	} dir_row_t;

	logic clk;
	logic arst_n;

	qsu_stream_if #(.payload_t(qsu_pkg::in_item_t))  text_if ();
	qsu_stream_if #(.payload_t(qsu_pkg::out_item_t)) result_if ();

	quoted_string_unescaper_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_if.sink),
		.result (result_if.source)
	);

	qsu_pkg::mode_t     scan_state;
	qsu_pkg::out_item_t step_results [$];
	qsu_pkg::out_item_t expected_results [$];
	dir_row_t           directed_rows [$];
	int                 error_count;
	int                 random_sent;
	int                 text_idle_pct;
	int                 result_stall_pct;
	int                 quiet_cycles;
	int                 text_idle_by_phase [4]   = '{0, 46, 0, 21};
	int                 result_stall_by_phase [4] = '{0, 0, 46, 21};

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic qsu_pkg::out_item_t mk_byte(input logic [7:0] b, input logic is_last);
		return qsu_pkg::out_item_t'{out_byte: b, is_status: 1'b0,
			quote_status: qsu_pkg::QST_NONE, last: is_last};
	endfunction

	function automatic qsu_pkg::out_item_t mk_status(input logic [1:0] st);
		return qsu_pkg::out_item_t'{out_byte: 8'h00, is_status: 1'b1, quote_status: st,
			last: 1'b1};
	endfunction

	function automatic qsu_pkg::in_item_t byte_item(input logic [7:0] b);
		return qsu_pkg::in_item_t'{action: qsu_pkg::ACT_BYTE, byte_value: b};
	endfunction

	function automatic qsu_pkg::in_item_t end_item(input logic [7:0] b);
		return qsu_pkg::in_item_t'{action: qsu_pkg::ACT_END, byte_value: b};
	endfunction

	function automatic void emit_char(input logic [7:0] b);
		step_results.push_back(mk_byte(b, 1'b0));
	endfunction

	// byte inside the quoted section, nothing pending
	function automatic void inside_char(input logic [7:0] b);
		if (b == qsu_pkg::QUOTE_CHAR) begin
			scan_state = qsu_pkg::MODE_QPEND;
		end else if (b == qsu_pkg::BACKSLASH_CHAR) begin
			scan_state = qsu_pkg::MODE_BSLASH;
		end else begin
			emit_char(b);
		end
	endfunction

	function automatic void unescape_step(input qsu_pkg::in_item_t it);
		logic [1:0] st;
		logic [7:0] b;
		b = it.byte_value;
		step_results.delete();
		if (it.action == qsu_pkg::ACT_END) begin
			case (scan_state)
				qsu_pkg::MODE_INSIDE: st = qsu_pkg::QST_OPEN;
				qsu_pkg::MODE_BSLASH: begin
					emit_char(qsu_pkg::BACKSLASH_CHAR);
					st = qsu_pkg::QST_OPEN;
				end
				qsu_pkg::MODE_QPEND, qsu_pkg::MODE_AFTER: st = qsu_pkg::QST_CLOSED;
				default: st = qsu_pkg::QST_NONE;
			endcase
			step_results.push_back(mk_status(st));
			scan_state = qsu_pkg::MODE_BEFORE;
		end else begin
			case (scan_state)
				qsu_pkg::MODE_INSIDE: inside_char(b);
				qsu_pkg::MODE_BSLASH: begin
					scan_state = qsu_pkg::MODE_INSIDE;
					if (b == qsu_pkg::LETTER_N) begin
						emit_char(qsu_pkg::NEWLINE_CHAR);
					end else if (b == qsu_pkg::LETTER_T) begin
						emit_char(qsu_pkg::TAB_CHAR);
					end else begin
						emit_char(qsu_pkg::BACKSLASH_CHAR);
						inside_char(b);
					end
				end
				qsu_pkg::MODE_QPEND: begin
					if (b == qsu_pkg::QUOTE_CHAR) begin
						emit_char(qsu_pkg::QUOTE_CHAR);
						scan_state = qsu_pkg::MODE_INSIDE;
					end else begin
						scan_state = qsu_pkg::MODE_AFTER;
						emit_char(b);
					end
				end
				qsu_pkg::MODE_AFTER: begin
					if (b != qsu_pkg::QUOTE_CHAR) emit_char(b);
				end
				default: begin
					if (b == qsu_pkg::QUOTE_CHAR) begin
						scan_state = qsu_pkg::MODE_INSIDE;
					end else begin
						scan_state = qsu_pkg::MODE_BEFORE;
						emit_char(b);
					end
				end
			endcase
		end
		if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
	endfunction

	function automatic void queue_predicted();
		foreach (step_results[i]) expected_results.push_back(step_results[i]);
	endfunction

	function automatic void add_row(input logic act, input logic [7:0] b, input bit typed = 1'b0,
			input int n = 0, input qsu_pkg::out_item_t r0 = '0,
			input qsu_pkg::out_item_t r1 = '0);
		dir_row_t row;
		row.item  = qsu_pkg::in_item_t'{action: act, byte_value: b};
		row.typed = typed;
		row.n     = n;
		row.r0    = r0;
		row.r1    = r1;
		directed_rows.push_back(row);
	endfunction

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(255));
		while (b == qsu_pkg::QUOTE_CHAR || b == qsu_pkg::BACKSLASH_CHAR);
		return b;
	endfunction

	// biased toward the characters the decoder reacts to
	function automatic logic [7:0] any_byte();
		int pick;
		pick = $urandom_range(99);
		if (pick < 25) return qsu_pkg::QUOTE_CHAR;
		if (pick < 40) return qsu_pkg::BACKSLASH_CHAR;
		if (pick < 45) return qsu_pkg::LETTER_N;
		if (pick < 50) return qsu_pkg::LETTER_T;
		return 8'($urandom_range(255));
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic check_result(input qsu_pkg::out_item_t got);
		qsu_pkg::out_item_t want;
		if (expected_results.size() == 0) begin
			report_mismatch($sformatf("unexpected result %h", got));
			return;
		end
		want = expected_results.pop_front();
		if (got.out_byte !== want.out_byte)
			report_mismatch($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
		if (got.is_status !== want.is_status)
			report_mismatch($sformatf("is_status %b, want %b", got.is_status, want.is_status));
		if (got.quote_status !== want.quote_status)
			report_mismatch($sformatf("quote_status %0d, want %0d",
				got.quote_status, want.quote_status));
		if (got.last !== want.last)
			report_mismatch($sformatf("last %b, want %b", got.last, want.last));
	endtask

	task automatic send_text(input qsu_pkg::in_item_t it);
		while ($urandom_range(99) < text_idle_pct) begin
			text_if.valid <= 1'b0;
			@(posedge clk);
		end
		text_if.valid   <= 1'b1;
		text_if.payload <= it;
		@(posedge clk);
		while (!text_if.ready) @(posedge clk);
	endtask

	task automatic send_predicted(input qsu_pkg::in_item_t it);
		send_text(it);
		unescape_step(it);
		queue_predicted();
		random_sent++;
	endtask

	task automatic send_random_string();
		qsu_pkg::in_item_t seq [$];
		int                kind;
		kind = $urandom_range(9);
		if (kind < 7) begin
			repeat ($urandom_range(3)) seq.push_back(byte_item(plain_byte()));
			seq.push_back(byte_item(qsu_pkg::QUOTE_CHAR));
			repeat ($urandom_range(8)) begin
				case ($urandom_range(5))
					0: begin
						seq.push_back(byte_item(qsu_pkg::BACKSLASH_CHAR));
						seq.push_back(byte_item(qsu_pkg::LETTER_N));
					end
					1: begin
						seq.push_back(byte_item(qsu_pkg::BACKSLASH_CHAR));
						seq.push_back(byte_item(qsu_pkg::LETTER_T));
					end
					2: begin
						seq.push_back(byte_item(qsu_pkg::BACKSLASH_CHAR));
						seq.push_back(byte_item(any_byte()));
					end
					3: begin
						seq.push_back(byte_item(qsu_pkg::QUOTE_CHAR));
						seq.push_back(byte_item(qsu_pkg::QUOTE_CHAR));
					end
					default: seq.push_back(byte_item(plain_byte()));
				endcase
			end
			if (kind < 6) begin
				seq.push_back(byte_item(qsu_pkg::QUOTE_CHAR));
				repeat ($urandom_range(3)) seq.push_back(byte_item(any_byte()));
			end else if ($urandom_range(1)) begin
				seq.push_back(byte_item(qsu_pkg::BACKSLASH_CHAR));
			end
		end else begin
			repeat ($urandom_range(10)) seq.push_back(byte_item(any_byte()));
		end
		seq.push_back(end_item(8'($urandom_range(255))));
		foreach (seq[i]) send_predicted(seq[i]);
	endtask

	always @(posedge clk) begin
		if (arst_n && result_if.valid && result_if.ready) check_result(result_if.payload);
		if (!arst_n)
			result_if.ready <= 1'b0;
		else
			result_if.ready <= ($urandom_range(99) >= result_stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else begin
			if ((text_if.valid && text_if.ready) || (result_if.valid && result_if.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t watchdog: no handshake for %0d cycles", $realtime, quiet_cycles);
				$display("quoted_string_unescaper_top_test: errors");
				$finish;
			end
		end
	end

	initial begin
		arst_n           = 1'b0;
		text_if.valid    = 1'b0;
		text_if.payload  = '0;
		scan_state       = qsu_pkg::MODE_BEFORE;
		error_count      = 0;
		random_sent      = 0;
		text_idle_pct    = 0;
		result_stall_pct = 0;

		add_row(qsu_pkg::ACT_BYTE, 8'h00, 1'b1, 1, mk_byte(8'h00, 1'b1));
		add_row(qsu_pkg::ACT_END, 8'h00, 1'b1, 1, mk_status(qsu_pkg::QST_NONE));
		add_row(qsu_pkg::ACT_BYTE, qsu_pkg::QUOTE_CHAR, 1'b1, 0);
		add_row(qsu_pkg::ACT_BYTE, qsu_pkg::BACKSLASH_CHAR);
		add_row(qsu_pkg::ACT_BYTE, qsu_pkg::LETTER_N);
		add_row(qsu_pkg::ACT_BYTE, qsu_pkg::BACKSLASH_CHAR);
		add_row(qsu_pkg::ACT_BYTE, qsu_pkg::LETTER_T);
		add_row(qsu_pkg::ACT_BYTE, qsu_pkg::BACKSLASH_CHAR);
		add_row(qsu_pkg::ACT_BYTE, 8'h78);
		add_row(qsu_pkg::ACT_BYTE, qsu_pkg::BACKSLASH_CHAR);
		add_row(qsu_pkg::ACT_BYTE, qsu_pkg::BACKSLASH_CHAR);
		add_row(qsu_pkg::ACT_BYTE, qsu_pkg::QUOTE_CHAR);
		add_row(qsu_pkg::ACT_BYTE, qsu_pkg::QUOTE_CHAR);
		add_row(qsu_pkg::ACT_BYTE, qsu_pkg::QUOTE_CHAR);
		add_row(qsu_pkg::ACT_BYTE, 8'h7A);
		add_row(qsu_pkg::ACT_BYTE, qsu_pkg::QUOTE_CHAR);
		add_row(qsu_pkg::ACT_BYTE, qsu_pkg::BACKSLASH_CHAR);
		add_row(qsu_pkg::ACT_BYTE, qsu_pkg::LETTER_N);
		add_row(qsu_pkg::ACT_END, 8'hFF, 1'b1, 1, mk_status(qsu_pkg::QST_CLOSED));
		add_row(qsu_pkg::ACT_BYTE, qsu_pkg::QUOTE_CHAR);
		add_row(qsu_pkg::ACT_BYTE, 8'hFF, 1'b1, 1, mk_byte(8'hFF, 1'b1));
		add_row(qsu_pkg::ACT_END, 8'h00, 1'b1, 1, mk_status(qsu_pkg::QST_OPEN));
		add_row(qsu_pkg::ACT_BYTE, qsu_pkg::QUOTE_CHAR);
		add_row(qsu_pkg::ACT_BYTE, qsu_pkg::BACKSLASH_CHAR);
		add_row(qsu_pkg::ACT_END, 8'h00, 1'b1, 2, mk_byte(qsu_pkg::BACKSLASH_CHAR, 1'b0),
			mk_status(qsu_pkg::QST_OPEN));
		add_row(qsu_pkg::ACT_BYTE, qsu_pkg::QUOTE_CHAR);
		add_row(qsu_pkg::ACT_BYTE, qsu_pkg::QUOTE_CHAR);
		add_row(qsu_pkg::ACT_END, 8'h00, 1'b1, 1, mk_status(qsu_pkg::QST_CLOSED));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			send_text(directed_rows[i].item);
			unescape_step(directed_rows[i].item);
			if (directed_rows[i].typed) begin
				if (directed_rows[i].n > 0) expected_results.push_back(directed_rows[i].r0);
				if (directed_rows[i].n > 1) expected_results.push_back(directed_rows[i].r1);
			end else begin
				queue_predicted();
			end
		end

		random_sent = 0;
		for (int ph = 0; ph < 4; ph++) begin
			text_idle_pct    = text_idle_by_phase[ph];
			result_stall_pct = result_stall_by_phase[ph];
			while (random_sent < (ph + 1) * RANDOM_ITEMS / 4) send_random_string();
			// hold off until the output side is empty
			while (expected_results.size() != 0) begin
				text_if.valid <= 1'b0;
				@(posedge clk);
			end
		end

		text_if.valid <= 1'b0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && expected_results.size() == 0) begin
			$display("quoted_string_unescaper_top_test: clean");
		end else begin
			$display("quoted_string_unescaper_top_test: errors");
		end
		$finish;
	end

endmodule
